FILE: src/rnta_pkg.sv
`default_nettype none

package rnta_pkg;

  localparam int unsigned ValueW        = 32;
  localparam int unsigned MagW          = ValueW + 1;
  localparam int unsigned TrialW        = ValueW + 2;
  localparam int unsigned CharW         = 7;
  localparam int unsigned DigitW        = 4;
  localparam int unsigned PosW          = 4;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharAlpha = 7'h41;
  localparam logic [CharW-1:0] CharMinus = 7'h2D;

  localparam logic [PosW-1:0] TopPosOct = 4'd10;
  localparam logic [PosW-1:0] TopPosDec = 4'd9;
  localparam logic [PosW-1:0] TopPosHex = 4'd7;

  localparam logic [1:0] SelOct = 2'd0;
  localparam logic [1:0] SelDec = 2'd1;

  typedef enum logic [1:0] {
    RADIX_OCT = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SIGN  = 3'b010,
    ST_DIGIT = 3'b100
  } state_e;

  typedef struct packed {
    radix_e          radix;
    logic            full;
    logic            minus;
    logic [MagW-1:0] mag;
  } item_t;

  function automatic logic [CharW-1:0] rnta_glyph(input logic [DigitW-1:0] digit);
    logic [CharW-1:0] code;
    if (digit < 4'd10) begin
      code = CharZero + {3'b000, digit};
    end else begin
      code = CharAlpha + {3'b000, digit - 4'd10};
    end
    return code;
  endfunction

  function automatic logic [ValueW-1:0] rnta_pow10(input logic [PosW-1:0] pos);
    logic [ValueW-1:0] p;
    case (pos)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: src/rnta_front.sv
`default_nettype none

module rnta_front import rnta_pkg::*; (
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [ValueW-1:0] value_i,
  input  wire logic        [1:0]        base_sel_i,
  input  wire logic                     queue_full_i,
  output logic                          push_o,
  output item_t                         item_o
);

  logic        neg;
  radix_e      radix;
  logic [ValueW-1:0] raw;

  always_comb begin
    raw = value_i;
    neg = raw[ValueW-1];
    case (base_sel_i)
      SelOct:  radix = RADIX_OCT;
      SelDec:  radix = RADIX_DEC;
      default: radix = RADIX_HEX;
    endcase

    item_o.radix = radix;
    item_o.minus = neg && (radix == RADIX_DEC);
    item_o.full  = neg && (radix != RADIX_DEC);
    if (radix == RADIX_DEC) begin
      item_o.mag = neg ? {1'b0, (~raw) + 32'd1} : {1'b0, raw};
    end else begin
      // octal negatives carry the sign into the 33rd bit
      item_o.mag = {neg && (radix == RADIX_OCT), raw};
    end

    in_stall_o = queue_full_i;
    push_o     = in_valid_i && !queue_full_i;
  end

endmodule

`default_nettype wire

FILE: src/rnta_queue.sv
`default_nettype none

module rnta_queue import rnta_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  input  wire logic  pop_i,
  output item_t      item_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  always_comb begin
    full_o  = (cnt_q == CntW'(Depth));
    empty_o = (cnt_q == '0);
    do_push = push_i && !full_o;
    do_pop  = pop_i && !empty_o;
    item_o  = mem_q[rd_ptr_q];

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/rnta_back.sv
`default_nettype none

module rnta_back import rnta_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire item_t             item_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CharW-1:0]       char_code_o,
  output logic                   last_char_o
);

  state_e             state_q, state_d;
  radix_e             radix_q, radix_d;
  logic               full_q, full_d;
  logic               started_q, started_d;
  logic [MagW-1:0]    mag_q, mag_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [1:0]         sub_q, sub_d;
  logic [DigitW-1:0]  dig_q, dig_d;
  logic               out_valid_q, out_valid_d;
  logic [CharW-1:0]   char_q, char_d;
  logic               last_q, last_d;

  logic               out_free;
  logic [TrialW-1:0]  trial;
  logic               ge;
  logic [DigitW-1:0]  cur_digit;
  logic               digit_end;
  logic               emit;

  always_comb begin
    out_free = !out_valid_q || !out_stall_i;
    pop_o    = (state_q == ST_IDLE) && !empty_i;

    // restoring step: compare against 8, 4, 2, 1 times the current power of ten
    trial = {2'b00, rnta_pow10(pos_q)} << (2'd3 - sub_q);
    ge    = {1'b0, mag_q} >= trial;

    case (radix_q)
      RADIX_DEC: cur_digit = {dig_q[3:1], ge};
      RADIX_OCT: cur_digit = {1'b0, mag_q[MagW-1 -: 3]};
      default:   cur_digit = mag_q[MagW-2 -: 4];
    endcase
    digit_end = (radix_q != RADIX_DEC) || (sub_q == 2'd3);
    emit      = full_q || started_q || (cur_digit != '0) || (pos_q == '0);

    state_d     = state_q;
    radix_d     = radix_q;
    full_d      = full_q;
    started_d   = started_q;
    mag_d       = mag_q;
    pos_d       = pos_q;
    sub_d       = sub_q;
    dig_d       = dig_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          radix_d   = item_i.radix;
          full_d    = item_i.full;
          mag_d     = item_i.mag;
          started_d = 1'b0;
          sub_d     = '0;
          dig_d     = '0;
          case (item_i.radix)
            RADIX_OCT: pos_d = TopPosOct;
            RADIX_DEC: pos_d = TopPosDec;
            default:   pos_d = TopPosHex;
          endcase
          state_d = item_i.minus ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CharMinus;
          last_d      = 1'b0;
          state_d     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (!digit_end || out_free) begin
          case (radix_q)
            RADIX_DEC: begin
              if (ge) begin
                mag_d = mag_q - trial[MagW-1:0];
              end
              dig_d[2'd3 - sub_q] = ge;
              sub_d = sub_q + 2'd1;
            end
            RADIX_OCT: mag_d = mag_q << 3;
            default:   mag_d = mag_q << 4;
          endcase
          if (digit_end) begin
            dig_d     = '0;
            started_d = started_q || emit;
            if (emit) begin
              out_valid_d = 1'b1;
              char_d      = rnta_glyph(cur_digit);
              last_d      = (pos_q == '0);
            end
            if (pos_q == '0) begin
              state_d = ST_IDLE;
            end else begin
              pos_d = pos_q - PosW'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q   <= radix_d;
    full_q    <= full_d;
    started_q <= started_d;
    mag_q     <= mag_d;
    pos_q     <= pos_d;
    sub_q     <= sub_d;
    dig_q     <= dig_d;
    char_q    <= char_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

FILE: src/radix_number_to_ascii.sv
// radix number to ascii converter
// input channel: in_valid_i / in_stall_o carry a signed 32-bit value_i and
// base_sel_i (0 octal, 1 decimal, 2 or 3 hexadecimal); one transfer per number
// output channel: out_valid_o / out_stall_i carry one character per transfer,
// char_code_o holds the ascii code and last_char_o marks the final character
// a number gives 1 to 11 characters, most significant first; negative decimal
// numbers start with a minus sign, negative octal and hex print the full-width
// complement pattern
// the front classifies each number and writes it into a small queue, so new
// numbers are taken while the back is still printing; in_stall_o is high only
// while that queue is full
// the back fetches a number from the queue, puts out a minus sign if needed,
// then steps through the digit positions, octal (11) and hex (8) by one shift
// per position, decimal (10) by a restoring compare-subtract against 8, 4, 2
// and 1 times a power of ten, one compare-subtract per cycle; the last step of
// each digit waits for a free output
// leading zeros are stepped through but not printed, except in a full-width pattern
// a stalled receiver holds the current character and the back waits on it
// reset clears the queue, the sequencer and the output valid; nothing else
`default_nettype none

module radix_number_to_ascii import rnta_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [ValueW-1:0] value_i,
  input  wire logic        [1:0]        base_sel_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic             [CharW-1:0]  char_code_o,
  output logic                          last_char_o
);

  item_t front_item;
  item_t queue_item;
  logic  push;
  logic  pop;
  logic  queue_full;
  logic  queue_empty;

  rnta_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .base_sel_i   (base_sel_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  rnta_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (queue_item),
    .full_o  (queue_full),
    .empty_o (queue_empty)
  );

  rnta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (queue_item),
    .empty_i     (queue_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

endmodule

`default_nettype wire

FILE: src/rnta_checker.sv
`default_nettype none

module rnta_checker import rnta_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_stall_o,
  input wire logic signed [ValueW-1:0] value_i,
  input wire logic        [1:0]        base_sel_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic        [CharW-1:0]  char_code_o,
  input wire logic                     last_char_o
);

  logic legal_char;
  logic unused_in;

  assign legal_char = ((char_code_o >= CharZero) && (char_code_o <= 7'h39)) ||
                      ((char_code_o >= CharAlpha) && (char_code_o <= 7'h46)) ||
                      (char_code_o == CharMinus);
  assign unused_in = in_valid_i ^ in_stall_o ^ (^value_i) ^ (^base_sel_i);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(char_code_o) && $stable(last_char_o))
    else $error("output payload changed while stalled");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> legal_char || unused_in != unused_in)
    else $error("character outside digit and sign set");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (char_code_o == CharMinus) |-> !last_char_o)
    else $error("minus sign flagged as final character");

  a_minus_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (char_code_o == CharMinus) ##1 out_valid_o
    |-> char_code_o != CharMinus)
    else $error("minus sign followed by another minus sign");

endmodule

bind radix_number_to_ascii rnta_checker u_checker (.*);

`default_nettype wire

FILE: tb/tb_radix_number_to_ascii.sv
`timescale 1ns / 100ps

module tb_radix_number_to_ascii;
  import rnta_pkg::*;

  localparam logic [1:0] SelUnused = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 105;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } ascii_char_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [ValueW-1:0] value;
  logic        [1:0]        base_sel;
  logic                     out_valid;
  logic                     out_stall;
  logic        [CharW-1:0]  char_code;
  logic                     last_char;

  ascii_char_t expected_chars[$];
  ascii_char_t want_char;
  int unsigned errors;
  int unsigned cycles;
  int unsigned stall_left;
  int unsigned stall_roll;
  logic        sender_gaps_on;
  logic        receiver_stalls_on;

  radix_number_to_ascii dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .value_i     (value),
    .base_sel_i  (base_sel),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .char_code_o (char_code),
    .last_char_o (last_char)
  );

  always #5 clk = ~clk;

  function automatic void predict_chars(input logic [ValueW-1:0] v, input logic [1:0] sel);
    logic [MagW-1:0]   mag;
    logic [DigitW-1:0] digs [11];
    int unsigned       rad;
    int unsigned       width;
    int unsigned       nd;
    logic              full;
    ascii_char_t       c;
    full = 1'b0;
    nd = 0;
    if (sel == RADIX_OCT) begin
      rad = 8;
      width = 11;
    end else if (sel == RADIX_DEC) begin
      rad = 10;
      width = 10;
    end else begin
      rad = 16;
      width = 8;
    end
    if (v[ValueW-1] && sel == RADIX_DEC) begin
      // most negative value wraps to 2^31, the right magnitude
      mag = {1'b0, 32'd0 - v};
      c.code = CharMinus;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end else if (v[ValueW-1]) begin
      mag = (sel == RADIX_OCT) ? {1'b1, v} : {1'b0, v};
      full = 1'b1;
    end else begin
      mag = {1'b0, v};
    end
    do begin
      digs[nd] = DigitW'(mag % rad);
      mag = mag / rad;
      nd++;
    end while (nd < width && (full || mag != 0));
    while (nd > 0) begin
      nd--;
      if (digs[nd] < 4'd10) begin
        c.code = CharW'(CharZero + digs[nd]);
      end else begin
        c.code = CharW'(CharAlpha + digs[nd] - 4'd10);
      end
      c.last = (nd == 0);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!sender_gaps_on || roll < 50) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [ValueW-1:0] pick_number();
    logic [ValueW-1:0] p;
    int unsigned       k;
    p = 32'd1;
    case ($urandom_range(0, 5))
      0, 1: begin
        return $urandom();
      end
      2: begin
        return 32'($urandom_range(0, 300));
      end
      3: begin
        return 32'd0 - 32'($urandom_range(1, 300));
      end
      4: begin
        k = $urandom_range(0, 31);
        return (32'd1 << k) + 32'($urandom_range(0, 2)) - 32'd1;
      end
      default: begin
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        p = p + 32'($urandom_range(0, 2)) - 32'd1;
        return ($urandom_range(0, 1) == 1) ? 32'd0 - p : p;
      end
    endcase
  endfunction

  task automatic send_number(input logic [ValueW-1:0] v, input logic [1:0] sel);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    value    <= v;
    base_sel <= sel;
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_chars(v, sel);
    gap = sender_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_for_all_chars();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic test_digit_boundaries();
    send_number(32'd0, RADIX_OCT);
    send_number(32'd0, RADIX_DEC);
    send_number(32'd0, RADIX_HEX);
    send_number(32'd7, RADIX_OCT);
    send_number(32'd8, RADIX_OCT);
    send_number(32'd9, RADIX_DEC);
    send_number(32'd10, RADIX_DEC);
    send_number(32'd15, RADIX_HEX);
    send_number(32'd16, RADIX_HEX);
    wait_for_all_chars();
  endtask

  task automatic test_signed_extremes();
    logic [1:0] sel;
    for (int s = 0; s < 3; s++) begin
      sel = 2'(s);
      send_number(32'h7FFF_FFFF, sel);
      send_number(32'h8000_0000, sel);
      send_number(32'hFFFF_FFFF, sel);
    end
    send_number(32'd0 - 32'd8, RADIX_OCT);
    send_number(32'd0 - 32'd10, RADIX_DEC);
    send_number(32'd0 - 32'd16, RADIX_HEX);
    wait_for_all_chars();
  endtask

  task automatic test_unused_selector();
    send_number(32'd0, SelUnused);
    send_number(32'hFFFF_FFFF, SelUnused);
    send_number(32'h89AB_CDEF, SelUnused);
    send_number(32'h1234_5678, SelUnused);
    wait_for_all_chars();
  endtask

  task automatic test_random_numbers();
    // back-to-back stretch first, then random idling on both sides, receiver only at the end
    sender_gaps_on = 1'b0;
    receiver_stalls_on = 1'b0;
    for (int i = 0; i < RandomItems; i++) begin
      if (i == 30) begin
        sender_gaps_on = 1'b1;
        receiver_stalls_on = 1'b1;
      end
      if (i == 80) begin
        wait_for_all_chars();
      end
      if (i == 100) begin
        sender_gaps_on = 1'b0;
      end
      send_number(pick_number(), 2'($urandom_range(0, 3)));
    end
    wait_for_all_chars();
  endtask

  always @(negedge clk) begin
    if (!receiver_stalls_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        out_stall <= 1'b1;
      end
    end
  end

  // one character per output transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("char_code: expected none, actual %h", char_code);
        errors++;
      end else begin
        want_char = expected_chars.pop_front();
        if (char_code !== want_char.code) begin
          $error("char_code: expected %h, actual %h", want_char.code, char_code);
          errors++;
        end
        if (last_char !== want_char.last) begin
          $error("last_char: expected %b, actual %b", want_char.last, last_char);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_radix_number_to_ascii: errors");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    value = '0;
    base_sel = RADIX_OCT;
    out_stall = 1'b0;
    errors = 0;
    cycles = 0;
    stall_left = 0;
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_digit_boundaries();
    test_signed_extremes();
    test_unused_selector();
    test_random_numbers();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("tb_radix_number_to_ascii: clean");
    end else begin
      $display("tb_radix_number_to_ascii: errors");
    end
    $finish;
  end

endmodule
